### rtl/core/assert_macros.svh
// Assertion macros shared by the tracking health RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that prop holds at every rising clock edge outside reset.
`define THS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tracking health assertion failed");
// Checks that cond is never true outside reset.
`define THS_NEVER(label, clk, rst_n, cond) \
  `THS_ASSERT(label, clk, rst_n, !(cond))
`else
`define THS_ASSERT(label, clk, rst_n, prop)
`define THS_NEVER(label, clk, rst_n, cond)
`endif
`endif

### rtl/core/ths_pkg.sv
// Types and constants of the tracking health state machine.
package ths_pkg;

  localparam int CNT_W  = 16;
  localparam int TIME_W = 32;
  localparam int DT_W   = 24;
  localparam int SEQ_W  = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Event kinds.
  localparam logic [1:0] EV_FRAME = 2'd0;
  localparam logic [1:0] EV_RELOC = 2'd1;
  localparam logic [1:0] EV_STOP  = 2'd2;

  // Frame quality codes.
  localparam logic [1:0] Q_FULL = 2'd0;
  localparam logic [1:0] Q_WEAK = 2'd1;
  localparam logic [1:0] Q_FAIL = 2'd2;

  // Failure reasons.
  localparam logic [1:0] R_NONE    = 2'd0;
  localparam logic [1:0] R_GEOM    = 2'd1;
  localparam logic [1:0] R_TIMEOUT = 2'd2;

  // Reported mode codes.
  localparam logic [2:0] TM_INIT  = 3'd0;
  localparam logic [2:0] TM_TRACK = 3'd1;
  localparam logic [2:0] TM_DEGR  = 3'd2;
  localparam logic [2:0] TM_RELOC = 3'd3;
  localparam logic [2:0] TM_LOST  = 3'd4;
  localparam logic [2:0] TM_STOP  = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_FRAMES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_FRAMES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEAK_FRAMES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_FRAMES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELOC_FRAMES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELOC_TIME     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRED_WINDOW    = 3'd6;

  typedef enum logic [5:0] {
    M_INIT  = 6'b000001,
    M_TRACK = 6'b000010,
    M_DEGR  = 6'b000100,
    M_RELOC = 6'b001000,
    M_LOST  = 6'b010000,
    M_STOP  = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [1:0]              frame_quality;
    logic                    reloc_success;
    logic signed [DT_W-1:0]  delta_time_us;
    logic [SEQ_W-1:0]        frame_sequence;
  } in_t;

  typedef struct packed {
    logic [2:0]       track_mode;
    logic [1:0]       reported_quality;
    logic [1:0]       failure_reason;
    logic [SEQ_W-1:0] echo_sequence;
    logic             pose_ok;
    logic             pose_predicted;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0]  init_frames_needed;
    logic [CNT_W-1:0]  recover_frames_needed;
    logic [CNT_W-1:0]  weak_frames_to_degrade;
    logic [CNT_W-1:0]  fail_frames_to_reloc;
    logic [CNT_W-1:0]  reloc_frame_limit;
    logic [TIME_W-1:0] reloc_time_limit_us;
    logic [TIME_W-1:0] prediction_window_us;
  } cfg_t;

endpackage

### rtl/core/tracking_health_state_machine.sv
// Top level of the tracking health state machine: input stage, update logic, result register.
//
// Each event passes through short update logic between an input register and a result
// register: a transaction is captured in the input register, the mode, streak counters
// and timers are updated as it moves into the result register, and a new event can be
// accepted every cycle while results are taken, so the block then sustains one event per
// clock. An event's status is presented from the result register once the event leaves
// the input register. While a result waits to be taken, the input register still accepts
// one more transaction; the input then stalls until the result is taken. Configuration
// writes take effect on the next clock and are meant to be made while no event is in flight.
`include "assert_macros.svh"
module tracking_health_state_machine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ths_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ths_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [ths_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ths_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ths_pkg::*;

  cfg_t cfg;
  in_t  ev_r;
  out_t res, out_r;
  logic ev_valid_r, out_valid_r, adv;

  // The held event moves on whenever the result register is free or being emptied.
  assign adv      = ev_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ev_valid_r || adv;

  ths_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ths_update u_update (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ev    (ev_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        ev_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_r <= in_data;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A held event that cannot move on stays held.
  `THS_ASSERT(a_hold_event, clk, rst_n, (ev_valid_r && !adv) |=> ev_valid_r)
  // With both stages full and the result not taken, no transaction is accepted.
  `THS_NEVER(a_no_overrun, clk, rst_n, ev_valid_r && out_valid_r && !out_ready && in_ready)

endmodule

### rtl/core/ths_cfg.sv
// Configuration register file of the tracking health state machine.
module ths_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ths_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ths_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ths_pkg::cfg_t                  cfg
);
  import ths_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_frames_needed     <= CNT_W'(3);
      cfg_r.recover_frames_needed  <= CNT_W'(5);
      cfg_r.weak_frames_to_degrade <= CNT_W'(5);
      cfg_r.fail_frames_to_reloc   <= CNT_W'(3);
      cfg_r.reloc_frame_limit      <= CNT_W'(30);
      cfg_r.reloc_time_limit_us    <= TIME_W'(3000000);
      cfg_r.prediction_window_us   <= TIME_W'(500000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INIT_FRAMES:    cfg_r.init_frames_needed     <= cfg_wdata[CNT_W-1:0];
        CFG_RECOVER_FRAMES: cfg_r.recover_frames_needed  <= cfg_wdata[CNT_W-1:0];
        CFG_WEAK_FRAMES:    cfg_r.weak_frames_to_degrade <= cfg_wdata[CNT_W-1:0];
        CFG_FAIL_FRAMES:    cfg_r.fail_frames_to_reloc   <= cfg_wdata[CNT_W-1:0];
        CFG_RELOC_FRAMES:   cfg_r.reloc_frame_limit      <= cfg_wdata[CNT_W-1:0];
        CFG_RELOC_TIME:     cfg_r.reloc_time_limit_us    <= cfg_wdata[TIME_W-1:0];
        CFG_PRED_WINDOW:    cfg_r.prediction_window_us   <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/ths_update.sv
// Tracking mode register, streak counters, timers and the per-event update logic.
`include "assert_macros.svh"
module ths_update (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  ths_pkg::in_t  ev,
  input  ths_pkg::cfg_t cfg,
  output ths_pkg::out_t res
);
  import ths_pkg::*;

  mode_t             mode_r, mode_nxt;
  logic [CNT_W-1:0]  full_r, full_nxt, weak_r, weak_nxt;
  logic [CNT_W-1:0]  fail_r, fail_nxt, rcnt_r, rcnt_nxt;
  logic [TIME_W-1:0] rtime_r, rtime_nxt, ptime_r, ptime_nxt;

  logic [CNT_W-1:0]  full_inc, weak_inc, fail_inc, rcnt_inc;
  logic [TIME_W-1:0] dt, rtime_sum, ptime_sum;
  logic [1:0]        fq;
  logic              reloc_hit, in_window, clr;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W:0] s;
    s = {1'b0, v} + {{CNT_W{1'b0}}, 1'b1};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    case (m)
      M_INIT:  c = TM_INIT;
      M_TRACK: c = TM_TRACK;
      M_DEGR:  c = TM_DEGR;
      M_RELOC: c = TM_RELOC;
      M_LOST:  c = TM_LOST;
      default: c = TM_STOP;
    endcase
    return c;
  endfunction

  always_comb begin
    // Negative elapsed time counts as zero.
    dt = ev.delta_time_us[DT_W-1] ? '0
                                  : {{(TIME_W-DT_W){1'b0}}, ev.delta_time_us[DT_W-1:0]};
    fq        = (ev.frame_quality inside {Q_FULL, Q_WEAK}) ? ev.frame_quality : Q_FAIL;
    full_inc  = sat_inc(full_r);
    weak_inc  = sat_inc(weak_r);
    fail_inc  = sat_inc(fail_r);
    rcnt_inc  = sat_inc(rcnt_r);
    rtime_sum = sat_add(rtime_r, dt);
    ptime_sum = sat_add(ptime_r, dt);
    reloc_hit = (rcnt_inc >= cfg.reloc_frame_limit) ||
                (rtime_sum >= cfg.reloc_time_limit_us);
    in_window = ptime_sum <= cfg.prediction_window_us;

    mode_nxt  = mode_r;
    full_nxt  = full_r;
    weak_nxt  = weak_r;
    fail_nxt  = fail_r;
    rcnt_nxt  = rcnt_r;
    rtime_nxt = rtime_r;
    ptime_nxt = ptime_r;
    clr       = 1'b0;

    res.reported_quality = Q_FAIL;
    res.failure_reason   = R_NONE;
    res.echo_sequence    = ev.frame_sequence;
    res.pose_ok          = 1'b0;
    res.pose_predicted   = 1'b0;

    case (ev.mode)
      EV_STOP: begin
        mode_nxt          = M_STOP;
        clr               = 1'b1;
        res.echo_sequence = '0;
      end
      EV_FRAME: begin
        case (mode_r)
          M_INIT: begin
            res.reported_quality = fq;
            if (fq == Q_FULL) begin
              full_nxt = full_inc;
              if (full_inc >= cfg.init_frames_needed) begin
                mode_nxt    = M_TRACK;
                clr         = 1'b1;
                res.pose_ok = 1'b1;
              end
            end else begin
              full_nxt = '0;
            end
          end
          M_TRACK, M_DEGR: begin
            res.reported_quality = fq;
            case (fq)
              Q_FULL: begin
                full_nxt    = full_inc;
                weak_nxt    = '0;
                fail_nxt    = '0;
                ptime_nxt   = '0;
                res.pose_ok = 1'b1;
                if (mode_r == M_DEGR && full_inc >= cfg.recover_frames_needed) begin
                  mode_nxt = M_TRACK;
                  clr      = 1'b1;
                end
              end
              Q_WEAK: begin
                weak_nxt    = weak_inc;
                full_nxt    = '0;
                fail_nxt    = '0;
                ptime_nxt   = '0;
                res.pose_ok = 1'b1;
                if (mode_r == M_TRACK && weak_inc >= cfg.weak_frames_to_degrade) begin
                  mode_nxt = M_DEGR;
                  clr      = 1'b1;
                end
              end
              default: begin
                fail_nxt           = fail_inc;
                full_nxt           = '0;
                weak_nxt           = '0;
                ptime_nxt          = ptime_sum;
                res.failure_reason = R_GEOM;
                res.pose_ok        = in_window;
                res.pose_predicted = in_window;
                if (fail_inc >= cfg.fail_frames_to_reloc) begin
                  mode_nxt = M_RELOC;
                  clr      = 1'b1;
                end
              end
            endcase
          end
          M_RELOC: begin
            rcnt_nxt  = rcnt_inc;
            rtime_nxt = rtime_sum;
            if (reloc_hit) begin
              mode_nxt           = M_LOST;
              clr                = 1'b1;
              res.failure_reason = R_TIMEOUT;
            end
          end
          default: ;
        endcase
      end
      EV_RELOC: begin
        if (mode_r == M_RELOC || mode_r == M_LOST) begin
          if (ev.reloc_success) begin
            mode_nxt             = M_TRACK;
            clr                  = 1'b1;
            res.reported_quality = Q_FULL;
            res.pose_ok          = 1'b1;
          end else if (mode_r == M_RELOC) begin
            rcnt_nxt  = rcnt_inc;
            rtime_nxt = rtime_sum;
            if (reloc_hit) begin
              mode_nxt           = M_LOST;
              clr                = 1'b1;
              res.failure_reason = R_TIMEOUT;
            end
          end
        end
      end
      default: ;
    endcase

    if (clr) begin
      full_nxt  = '0;
      weak_nxt  = '0;
      fail_nxt  = '0;
      rcnt_nxt  = '0;
      rtime_nxt = '0;
      ptime_nxt = '0;
    end

    res.track_mode = mode_code(mode_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_INIT;
      full_r  <= '0;
      weak_r  <= '0;
      fail_r  <= '0;
      rcnt_r  <= '0;
      rtime_r <= '0;
      ptime_r <= '0;
    end else if (adv) begin
      mode_r  <= mode_nxt;
      full_r  <= full_nxt;
      weak_r  <= weak_nxt;
      fail_r  <= fail_nxt;
      rcnt_r  <= rcnt_nxt;
      rtime_r <= rtime_nxt;
      ptime_r <= ptime_nxt;
    end
  end

  // Stopped is left only through reset.
  `THS_ASSERT(a_stop_sticky, clk, rst_n, (mode_r == M_STOP) |=> (mode_r == M_STOP))
  // Every mode change starts from cleared counters and timers.
  `THS_ASSERT(a_clear_on_change, clk, rst_n, (adv && mode_nxt != mode_r) |=>
              (full_r == '0 && weak_r == '0 && fail_r == '0 && rcnt_r == '0 &&
               rtime_r == '0 && ptime_r == '0))
  // A prediction-only pose is always a published pose.
  `THS_NEVER(a_pred_needs_pose, clk, rst_n, res.pose_predicted && !res.pose_ok)

endmodule

### tb/ths_tb_pkg.sv
// Status predictor and scoreboard used by the tracking health state machine testbench.
package ths_tb_pkg;
  import ths_pkg::*;

  // Codes outside the defined ranges, still carried by the two-bit fields.
  localparam logic [1:0] EV_UNKNOWN = 2'd3;
  localparam logic [1:0] Q_UNKNOWN  = 2'd3;

  class health_scoreboard;
    logic [CNT_W-1:0]  init_need, recover_need, weak_need, fail_need, reloc_tries_max;
    logic [TIME_W-1:0] reloc_time_max, predict_window;

    logic [2:0]        mode;
    logic [CNT_W-1:0]  full_run, weak_run, fail_run, reloc_tries;
    logic [TIME_W-1:0] reloc_us, predict_us;

    out_t expected_status[$];
    int   events_seen;
    int   statuses_checked;
    int   errors;

    function new();
      init_need       = 16'd3;
      recover_need    = 16'd5;
      weak_need       = 16'd5;
      fail_need       = 16'd3;
      reloc_tries_max = 16'd30;
      reloc_time_max  = 32'd3000000;
      predict_window  = 32'd500000;
      mode            = TM_INIT;
      clear_streaks();
      events_seen      = 0;
      statuses_checked = 0;
      errors           = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_INIT_FRAMES:    init_need       = value[CNT_W-1:0];
        CFG_RECOVER_FRAMES: recover_need    = value[CNT_W-1:0];
        CFG_WEAK_FRAMES:    weak_need       = value[CNT_W-1:0];
        CFG_FAIL_FRAMES:    fail_need       = value[CNT_W-1:0];
        CFG_RELOC_FRAMES:   reloc_tries_max = value[CNT_W-1:0];
        CFG_RELOC_TIME:     reloc_time_max  = value;
        CFG_PRED_WINDOW:    predict_window  = value;
        default: ;
      endcase
    endfunction

    function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    function void clear_streaks();
      full_run    = '0;
      weak_run    = '0;
      fail_run    = '0;
      reloc_tries = '0;
      reloc_us    = '0;
      predict_us  = '0;
    endfunction

    function out_t status(logic [2:0] m, logic [1:0] q, logic [1:0] r, logic [SEQ_W-1:0] seq,
                          logic pv, logic po);
      out_t s;
      s.track_mode       = m;
      s.reported_quality = q;
      s.failure_reason   = r;
      s.echo_sequence    = seq;
      s.pose_ok          = pv;
      s.pose_predicted   = po;
      return s;
    endfunction

    // One relocalization attempt; true once either budget is used up.
    function logic reloc_attempt(logic [TIME_W-1:0] dt);
      reloc_tries = sat_inc(reloc_tries);
      reloc_us    = sat_add(reloc_us, dt);
      return (reloc_tries >= reloc_tries_max) || (reloc_us >= reloc_time_max);
    endfunction

    function out_t frame_status(logic [1:0] q_in, logic [TIME_W-1:0] dt, logic [SEQ_W-1:0] seq);
      logic [1:0] q;
      logic       in_window;
      out_t       s;
      q = (q_in == Q_UNKNOWN) ? Q_FAIL : q_in;
      case (mode)
        TM_INIT: begin
          if (q == Q_FULL) full_run = sat_inc(full_run);
          else full_run = '0;
          if (q == Q_FULL && full_run >= init_need) begin
            mode = TM_TRACK;
            clear_streaks();
            s = status(TM_TRACK, Q_FULL, R_NONE, seq, 1'b1, 1'b0);
          end else begin
            s = status(TM_INIT, q, R_NONE, seq, 1'b0, 1'b0);
          end
        end
        TM_TRACK, TM_DEGR: begin
          if (q == Q_FULL) begin
            full_run   = sat_inc(full_run);
            weak_run   = '0;
            fail_run   = '0;
            predict_us = '0;
            if (mode == TM_DEGR && full_run >= recover_need) begin
              mode = TM_TRACK;
              clear_streaks();
            end
            s = status(mode, Q_FULL, R_NONE, seq, 1'b1, 1'b0);
          end else if (q == Q_WEAK) begin
            weak_run   = sat_inc(weak_run);
            full_run   = '0;
            fail_run   = '0;
            predict_us = '0;
            if (mode == TM_TRACK && weak_run >= weak_need) begin
              mode = TM_DEGR;
              clear_streaks();
            end
            s = status(mode, Q_WEAK, R_NONE, seq, 1'b1, 1'b0);
          end else begin
            fail_run   = sat_inc(fail_run);
            full_run   = '0;
            weak_run   = '0;
            predict_us = sat_add(predict_us, dt);
            in_window  = (predict_us <= predict_window);
            if (fail_run >= fail_need) begin
              mode = TM_RELOC;
              clear_streaks();
            end
            s = status(mode, Q_FAIL, R_GEOM, seq, in_window, in_window);
          end
        end
        TM_RELOC: begin
          if (reloc_attempt(dt)) begin
            mode = TM_LOST;
            clear_streaks();
            s = status(TM_LOST, Q_FAIL, R_TIMEOUT, seq, 1'b0, 1'b0);
          end else begin
            s = status(TM_RELOC, Q_FAIL, R_NONE, seq, 1'b0, 1'b0);
          end
        end
        default: s = status(mode, Q_FAIL, R_NONE, seq, 1'b0, 1'b0);
      endcase
      return s;
    endfunction

    function out_t reloc_status(logic ok, logic [TIME_W-1:0] dt, logic [SEQ_W-1:0] seq);
      out_t s;
      if (mode == TM_RELOC || mode == TM_LOST) begin
        if (ok) begin
          mode = TM_TRACK;
          clear_streaks();
          s = status(TM_TRACK, Q_FULL, R_NONE, seq, 1'b1, 1'b0);
        end else if (mode == TM_RELOC) begin
          if (reloc_attempt(dt)) begin
            mode = TM_LOST;
            clear_streaks();
            s = status(TM_LOST, Q_FAIL, R_TIMEOUT, seq, 1'b0, 1'b0);
          end else begin
            s = status(TM_RELOC, Q_FAIL, R_NONE, seq, 1'b0, 1'b0);
          end
        end else begin
          s = status(TM_LOST, Q_FAIL, R_NONE, seq, 1'b0, 1'b0);
        end
      end else begin
        // A relocalization result outside relocalization leaves the state alone.
        s = status(mode, Q_FAIL, R_NONE, seq, 1'b0, 1'b0);
      end
      return s;
    endfunction

    function out_t predict_status(in_t ev);
      logic [TIME_W-1:0] dt;
      out_t              s;
      // Negative elapsed times count as zero.
      dt = ev.delta_time_us[DT_W-1] ? '0 : {{(TIME_W-DT_W){1'b0}}, ev.delta_time_us};
      if (ev.mode == EV_STOP) begin
        mode = TM_STOP;
        clear_streaks();
        s = status(TM_STOP, Q_FAIL, R_NONE, '0, 1'b0, 1'b0);
      end else if (mode == TM_STOP) begin
        s = status(TM_STOP, Q_FAIL, R_NONE, ev.frame_sequence, 1'b0, 1'b0);
      end else if (ev.mode == EV_FRAME) begin
        s = frame_status(ev.frame_quality, dt, ev.frame_sequence);
      end else if (ev.mode == EV_RELOC) begin
        s = reloc_status(ev.reloc_success, dt, ev.frame_sequence);
      end else begin
        s = status(mode, Q_FAIL, R_NONE, ev.frame_sequence, 1'b0, 1'b0);
      end
      return s;
    endfunction

    function void note_event(in_t ev);
      expected_status.push_back(predict_status(ev));
      events_seen++;
    endfunction

    function void compare_field(string name, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_status(out_t got);
      out_t want;
      if (expected_status.size() == 0) begin
        errors++;
        $display("%0t: status with no event outstanding: expected none, actual %h", $time, got);
        return;
      end
      want = expected_status.pop_front();
      statuses_checked++;
      compare_field("track_mode", want.track_mode, got.track_mode);
      compare_field("reported_quality", want.reported_quality, got.reported_quality);
      compare_field("failure_reason", want.failure_reason, got.failure_reason);
      compare_field("echo_sequence", want.echo_sequence, got.echo_sequence);
      compare_field("pose_ok", want.pose_ok, got.pose_ok);
      compare_field("pose_predicted", want.pose_predicted, got.pose_predicted);
    endfunction
  endclass

endpackage

### tb/tb_tracking_health_state_machine.sv
// Testbench top for the tracking health state machine: stimulus, handshakes and checking.
module tb_tracking_health_state_machine;
  import ths_pkg::*;
  import ths_tb_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [DT_W-1:0]  DT_MAX  = 24'h7FFFFF;
  localparam logic [DT_W-1:0]  DT_MIN  = 24'h800000;
  localparam logic [SEQ_W-1:0] SEQ_TOP = '1;

  typedef enum int {SET_ZERO, SET_MAX, SET_ONE, SET_DEFAULT, SET_RANDOM} cfg_style_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  health_scoreboard sb = new();

  int         idle_run;
  bit         hold_req;
  int         ready_pct;
  int         pattern_left;
  int         burst_left;
  bit         gaps_on;
  int         hold_at;
  int         full_pct;
  int         weak_pct;
  int         dt_span;
  int         run_left;
  logic [1:0] run_q;
  int         config_loads;

  tracking_health_state_machine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_status(out_data);
  end

  initial begin
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("%0t: no transaction for %0d cycles, giving up", $time, IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: ready follows a changing duty pattern, or holds off when asked.
  initial begin
    out_ready    = 1'b0;
    ready_pct    = 100;
    pattern_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(3))
            0: ready_pct = 100;
            1: ready_pct = 80;
            2: ready_pct = 50;
            default: ready_pct = 25;
          endcase
          pattern_left = $urandom_range(20, 150);
        end
        pattern_left--;
        out_ready <= ($urandom_range(99) < ready_pct);
      end
    end
  end

  function automatic in_t make_event(input logic [1:0] kind, input logic [1:0] q,
                                     input logic ok, input logic [DT_W-1:0] dt,
                                     input logic [SEQ_W-1:0] seq);
    in_t ev;
    ev.mode           = kind;
    ev.frame_quality  = q;
    ev.reloc_success  = ok;
    ev.delta_time_us  = dt;
    ev.frame_sequence = seq;
    return ev;
  endfunction

  // Frame qualities come in runs so that streak thresholds are actually reached.
  function automatic in_t next_random_event();
    logic [1:0]       kind;
    logic [DT_W-1:0]  dt;
    logic [SEQ_W-1:0] seq;
    int               roll;
    int               reloc_pct;
    reloc_pct = (sb.mode == TM_RELOC || sb.mode == TM_LOST) ? 40 : 6;
    roll = $urandom_range(99);
    if (roll < 3) kind = EV_UNKNOWN;
    else if (roll < 3 + reloc_pct) kind = EV_RELOC;
    else kind = EV_FRAME;
    if (run_left == 0) begin
      roll = $urandom_range(99);
      if (roll < full_pct) run_q = Q_FULL;
      else if (roll < full_pct + weak_pct) run_q = Q_WEAK;
      else run_q = ($urandom_range(7) == 0) ? Q_UNKNOWN : Q_FAIL;
      run_left = $urandom_range(1, 8);
    end
    run_left--;
    roll = $urandom_range(99);
    if (roll < 8) dt = DT_MIN | DT_W'($urandom());
    else if (roll < 16) dt = DT_W'($urandom_range(0, 8388607));
    else dt = DT_W'($urandom_range(0, dt_span));
    roll = $urandom_range(99);
    if (roll < 3) seq = '0;
    else if (roll < 6) seq = SEQ_TOP;
    else seq = SEQ_W'({$urandom(), $urandom()});
    return make_event(kind, run_q, ($urandom_range(99) < 30), dt, seq);
  endfunction

  function automatic logic [CNT_W-1:0] small_count();
    return ($urandom_range(9) == 0) ? CNT_W'($urandom()) : CNT_W'($urandom_range(0, 7));
  endfunction

  function automatic cfg_t pick_config(input cfg_style_t style);
    cfg_t c;
    case (style)
      SET_ZERO: c = '0;
      SET_MAX:  c = '1;
      SET_ONE: begin
        c.init_frames_needed     = 16'd1;
        c.recover_frames_needed  = 16'd1;
        c.weak_frames_to_degrade = 16'd1;
        c.fail_frames_to_reloc   = 16'd1;
        c.reloc_frame_limit      = 16'd1;
        c.reloc_time_limit_us    = '0;
        c.prediction_window_us   = '0;
      end
      SET_DEFAULT: begin
        c.init_frames_needed     = 16'd3;
        c.recover_frames_needed  = 16'd5;
        c.weak_frames_to_degrade = 16'd5;
        c.fail_frames_to_reloc   = 16'd3;
        c.reloc_frame_limit      = 16'd30;
        c.reloc_time_limit_us    = 32'd3000000;
        c.prediction_window_us   = 32'd500000;
      end
      default: begin
        c.init_frames_needed     = small_count();
        c.recover_frames_needed  = small_count();
        c.weak_frames_to_degrade = small_count();
        c.fail_frames_to_reloc   = small_count();
        c.reloc_frame_limit      = small_count();
        c.reloc_time_limit_us    = ($urandom_range(3) == 0) ? $urandom()
                                                            : $urandom_range(0, 2000000);
        c.prediction_window_us   = $urandom_range(0, 600000);
      end
    endcase
    return c;
  endfunction

  // The transaction completes at the first edge that sees ready with valid high.
  task automatic send_item(input in_t ev);
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    sb.note_event(ev);
  endtask

  task automatic idle_for(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic pace();
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        idle_for($urandom_range(1, 12));
      end
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
  endtask

  // Upper bits of the 16-bit registers carry noise; only the low half counts.
  task automatic apply_config(input cfg_t c);
    write_reg(CFG_INIT_FRAMES, {16'($urandom()), c.init_frames_needed});
    write_reg(CFG_RECOVER_FRAMES, {16'($urandom()), c.recover_frames_needed});
    write_reg(CFG_WEAK_FRAMES, {16'($urandom()), c.weak_frames_to_degrade});
    write_reg(CFG_FAIL_FRAMES, {16'($urandom()), c.fail_frames_to_reloc});
    write_reg(CFG_RELOC_FRAMES, {16'($urandom()), c.reloc_frame_limit});
    write_reg(CFG_RELOC_TIME, c.reloc_time_limit_us);
    write_reg(CFG_PRED_WINDOW, c.prediction_window_us);
    @(posedge clk);
    cfg_we <= 1'b0;
    config_loads++;
  endtask

  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(next_random_event());
      if (i == hold_at) hold_req = 1'b1;
      pace();
    end
    wait_results();
  endtask

  initial begin
    cfg_t sat_cfg;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    hold_req     = 1'b0;
    gaps_on      = 1'b0;
    burst_left   = 1;
    hold_at      = -1;
    run_left     = 0;
    run_q        = Q_FULL;
    full_pct     = 50;
    weak_pct     = 25;
    dt_span      = 200000;
    config_loads = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk through the reset configuration.
    send_item(make_event(EV_FRAME, Q_WEAK, 1'b0, 24'd0, 48'd0));
    send_item(make_event(EV_FRAME, Q_UNKNOWN, 1'b1, 24'hFFFFFF, SEQ_TOP));
    for (int i = 0; i < 3; i++) send_item(make_event(EV_FRAME, Q_FULL, 1'b0, 24'd1000, 48'(100 + i)));
    send_item(make_event(EV_UNKNOWN, Q_FULL, 1'b1, 24'd5, 48'h1234));
    send_item(make_event(EV_RELOC, Q_WEAK, 1'b1, 24'd5, 48'h1235));
    for (int i = 0; i < 5; i++) send_item(make_event(EV_FRAME, Q_WEAK, 1'b0, 24'd2000, 48'(200 + i)));
    for (int i = 0; i < 5; i++) send_item(make_event(EV_FRAME, Q_FULL, 1'b1, 24'd2000, 48'(300 + i)));
    send_item(make_event(EV_FRAME, Q_FAIL, 1'b0, DT_MIN, 48'h400));
    send_item(make_event(EV_FRAME, Q_FAIL, 1'b0, DT_MAX, 48'h401));
    send_item(make_event(EV_FRAME, Q_FAIL, 1'b0, 24'd100, 48'h402));
    send_item(make_event(EV_RELOC, Q_FULL, 1'b0, 24'd1000, 48'h403));
    send_item(make_event(EV_FRAME, Q_FULL, 1'b0, 24'd2000, 48'h404));
    send_item(make_event(EV_RELOC, Q_FAIL, 1'b1, 24'd10, 48'h405));
    wait_results();

    gaps_on = 1'b1;
    run_phase(150);

    for (int p = 0; p < 8; p++) begin
      apply_config(pick_config((p < 4) ? cfg_style_t'(p) : SET_RANDOM));
      full_pct = $urandom_range(20, 70);
      weak_pct = $urandom_range(5, 95 - full_pct);
      dt_span  = $urandom_range(1000, 400000);
      gaps_on  = (p % 3 != 1);
      hold_at  = (p == 2 || p == 6) ? 40 : -1;
      run_phase(92);
    end
    hold_at = -1;

    // Drive both timers into saturation with maximum steps.
    sat_cfg.init_frames_needed     = 16'd1;
    sat_cfg.recover_frames_needed  = '1;
    sat_cfg.weak_frames_to_degrade = '1;
    sat_cfg.fail_frames_to_reloc   = '1;
    sat_cfg.reloc_frame_limit      = '1;
    sat_cfg.reloc_time_limit_us    = '1;
    sat_cfg.prediction_window_us   = 32'hFFFFFFFE;
    apply_config(sat_cfg);
    gaps_on = 1'b1;
    send_item(make_event(EV_RELOC, Q_FULL, 1'b1, 24'd0, 48'h5000));
    pace();
    send_item(make_event(EV_FRAME, Q_FULL, 1'b0, 24'd0, 48'h5001));
    pace();
    for (int i = 0; i < 520; i++) begin
      send_item(make_event(EV_FRAME, Q_FAIL, 1'($urandom()), DT_MAX, SEQ_W'({$urandom(), $urandom()})));
      pace();
    end
    wait_results();
    sat_cfg.fail_frames_to_reloc = 16'd1;
    apply_config(sat_cfg);
    send_item(make_event(EV_FRAME, Q_FAIL, 1'b0, 24'd0, 48'h6000));
    for (int i = 0; i < 520; i++) begin
      if (i % 2 == 0) send_item(make_event(EV_RELOC, 2'($urandom()), 1'b0, DT_MAX, 48'(i)));
      else send_item(make_event(EV_FRAME, Q_FULL, 1'b1, DT_MAX, 48'(i)));
      pace();
    end
    send_item(make_event(EV_RELOC, Q_FAIL, 1'b1, 24'd0, 48'h6001));
    wait_results();

    // Stop is permanent, so it comes last.
    send_item(make_event(EV_STOP, Q_WEAK, 1'b1, 24'd77, 48'hABCDEF));
    send_item(make_event(EV_FRAME, Q_FULL, 1'b0, 24'd10, 48'h7000));
    send_item(make_event(EV_RELOC, Q_FULL, 1'b1, 24'd10, 48'h7001));
    send_item(make_event(EV_UNKNOWN, Q_UNKNOWN, 1'b0, 24'd10, 48'h7002));
    send_item(make_event(EV_STOP, Q_FULL, 1'b0, DT_MIN, SEQ_TOP));
    wait_results();
    repeat (8) @(posedge clk);

    $display("Checked %0d statuses from %0d events over %0d configuration loads, %0d mismatches.",
             sb.statuses_checked, sb.events_seen, config_loads, sb.errors);
    $display("Covered mode transitions, extreme settings, timer saturation, output stalls and stop.");
    if (sb.errors == 0 && sb.expected_status.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ths_pkg.sv
rtl/core/ths_cfg.sv
rtl/core/ths_update.sv
rtl/core/tracking_health_state_machine.sv
tb/ths_tb_pkg.sv
tb/tb_tracking_health_state_machine.sv
